// ===== rtl/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, constants and helpers for the bulk transfer packet segmenter.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Largest endpoint packet in bytes (legal range 8 to 64)
  localparam int unsigned MAX_PACKET = 64;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned PKT_W  = 7;
  localparam int unsigned TXS_W  = 2;

  localparam logic [PKT_W-1:0] MAX_PKT_LEN = PKT_W'(MAX_PACKET);

  // Item kinds on the input channel
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_SENT  = 1'b1;

  // Reported transmit state codes
  localparam logic [TXS_W-1:0] TXS_READY      = 2'd0;
  localparam logic [TXS_W-1:0] TXS_BUSY       = 2'd1;
  localparam logic [TXS_W-1:0] TXS_BUSY_ZLP   = 2'd2;
  localparam logic [TXS_W-1:0] TXS_COMPLETING = 2'd3;

  // Transfer phase, one-hot
  typedef enum logic [3:0] {
    PH_READY      = 4'b0001,
    PH_BUSY       = 4'b0010,
    PH_BUSY_ZLP   = 4'b0100,
    PH_COMPLETING = 4'b1000
  } phase_t;

  // Transfer context kept between beats
  typedef struct packed {
    phase_t             phase;
    logic [LEN_W-1:0]   bytes_left;
    logic [ADDR_W-1:0]  cursor_address;
    logic [PKT_W-1:0]   last_packet_length;
  } xfer_state_t;

  // One result beat
  typedef struct packed {
    logic               packet_issued;
    logic [ADDR_W-1:0]  packet_address;
    logic [PKT_W-1:0]   packet_length;
    logic               start_accepted;
    logic [TXS_W-1:0]   tx_state;
  } result_t;

  // Map the one-hot phase to its reported code
  function automatic logic [TXS_W-1:0] phase_code(phase_t ph);
    logic [TXS_W-1:0] code;
    code = TXS_READY;
    unique case (ph)
      PH_READY:      code = TXS_READY;
      PH_BUSY:       code = TXS_BUSY;
      PH_BUSY_ZLP:   code = TXS_BUSY_ZLP;
      PH_COMPLETING: code = TXS_COMPLETING;
      default:       code = TXS_READY;
    endcase
    return code;
  endfunction

  // Size of the next packet for a given remaining byte count
  function automatic logic [PKT_W-1:0] chunk_of(logic [LEN_W-1:0] remaining);
    logic [PKT_W-1:0] len;
    if (remaining < LEN_W'(MAX_PACKET)) begin
      len = remaining[PKT_W-1:0];
    end else begin
      len = MAX_PKT_LEN;
    end
    return len;
  endfunction

endpackage

// ===== rtl/bulk_transfer_packet_segmenter.sv =====
// ----------------------------------------------------------------------------
// bulk_transfer_packet_segmenter
// Splits a bulk IN transmit request into endpoint packets.
// ----------------------------------------------------------------------------
// A mode 0 beat starts a transfer (start_address, transfer_length) when the
// segmenter is ready and issues the first packet of at most MAX_PACKET bytes
// at once; a mode 0 beat at any other time is dropped with start_accepted low.
// Each mode 1 beat reports that the previous packet went out: it issues the
// next packet, a zero-length packet after a full final packet, or moves the
// transfer to completing and then back to ready. Every input beat yields
// exactly one result beat carrying the state after that beat. One beat per
// cycle is sustained: the transfer context updates on each accepted beat and the
// result sits in an output register backed by a skid stage, so in_ready only
// drops when two results are waiting.
// ----------------------------------------------------------------------------
module bulk_transfer_packet_segmenter import bts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [ADDR_W-1:0]  start_address,
  input  logic [LEN_W-1:0]   transfer_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               packet_issued,
  output logic [ADDR_W-1:0]  packet_address,
  output logic [PKT_W-1:0]   packet_length,
  output logic               start_accepted,
  output logic [TXS_W-1:0]   tx_state
);

  xfer_state_t state;
  xfer_state_t state_next;
  result_t     step_res;
  result_t     out_data;
  logic        in_fire;

  assign in_fire = in_valid && in_ready;

  bts_step u_step (
    .cur             (state),
    .mode            (mode),
    .start_address   (start_address),
    .transfer_length (transfer_length),
    .nxt             (state_next),
    .res             (step_res)
  );

  // Hold transfer context; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase              <= PH_READY;
      state.bytes_left         <= '0;
      state.cursor_address     <= '0;
      state.last_packet_length <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  bts_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (step_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign packet_issued  = out_data.packet_issued;
  assign packet_address = out_data.packet_address;
  assign packet_length  = out_data.packet_length;
  assign start_accepted = out_data.start_accepted;
  assign tx_state       = out_data.tx_state;

endmodule

// ===== rtl/bts_step.sv =====
// ----------------------------------------------------------------------------
// bts_step
// Next-state and result logic for one beat: start a transfer or react to a
// packet-sent event.
// ----------------------------------------------------------------------------
module bts_step import bts_pkg::*; (
  input  xfer_state_t        cur,
  input  logic               mode,
  input  logic [ADDR_W-1:0]  start_address,
  input  logic [LEN_W-1:0]   transfer_length,
  output xfer_state_t        nxt,
  output result_t            res
);

  logic [LEN_W-1:0] sent;
  logic [LEN_W-1:0] left_after;
  logic [PKT_W-1:0] first_len;

  // Bytes retired by the packet just sent, never more than what is left
  always_comb begin
    sent = LEN_W'(cur.last_packet_length);
    if (sent > cur.bytes_left) begin
      sent = cur.bytes_left;
    end
  end

  assign left_after = cur.bytes_left - sent;
  assign first_len  = chunk_of(transfer_length);

  // Decide the transition and the packet to hand out
  always_comb begin
    nxt = cur;
    res = '0;
    if (mode == MODE_START) begin
      if (cur.phase == PH_READY) begin
        nxt.phase              = PH_BUSY;
        nxt.cursor_address     = start_address;
        nxt.bytes_left         = transfer_length;
        nxt.last_packet_length = first_len;
        res.start_accepted     = 1'b1;
        res.packet_issued      = 1'b1;
        res.packet_address     = start_address;
        res.packet_length      = first_len;
      end
    end else begin
      unique case (cur.phase)
        PH_COMPLETING: nxt.phase = PH_READY;
        PH_BUSY_ZLP:   nxt.phase = PH_COMPLETING;
        PH_BUSY: begin
          nxt.bytes_left     = left_after;
          nxt.cursor_address = cur.cursor_address + sent;
          if (left_after != '0) begin
            nxt.last_packet_length = chunk_of(left_after);
            res.packet_issued      = 1'b1;
            res.packet_address     = cur.cursor_address + sent;
            res.packet_length      = chunk_of(left_after);
          end else if (cur.last_packet_length == MAX_PKT_LEN) begin
            // Full final packet: terminate with a zero-length packet
            nxt.last_packet_length = '0;
            nxt.phase              = PH_BUSY_ZLP;
            res.packet_issued      = 1'b1;
          end else begin
            nxt.phase = PH_COMPLETING;
          end
        end
        default: nxt.phase = cur.phase;
      endcase
    end
    res.tx_state = phase_code(nxt.phase);
  end

endmodule

// ===== rtl/bts_out_buf.sv =====
// ----------------------------------------------------------------------------
// bts_out_buf
// Output register with a skid stage so the input side keeps flowing while a
// result waits to be taken.
// ----------------------------------------------------------------------------
module bts_out_buf import bts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  result_t  push_data,
  output logic     can_push,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  // Control: valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (pop && skid_valid) begin
        skid_valid <= 1'b0;
      end else if (push && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (push) begin
        skid_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: move skid forward, load output or park in skid
  always_ff @(posedge clk) begin
    priority if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (!out_valid || pop)) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/bts_checker.sv =====
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks for the bulk transfer packet segmenter.
// ----------------------------------------------------------------------------
module bts_checker import bts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               packet_issued,
  input  logic [ADDR_W-1:0]  packet_address,
  input  logic [PKT_W-1:0]   packet_length,
  input  logic               start_accepted,
  input  logic [TXS_W-1:0]   tx_state
);

  // An accepted start always issues its first packet and leaves us busy
  a_start_issues: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_accepted |-> packet_issued && tx_state == TXS_BUSY)
    else $error("accepted start without first packet or busy state");

  // Packets never exceed the endpoint size
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> packet_length <= MAX_PKT_LEN)
    else $error("packet length above MAX_PACKET");

  // No packet means zero address and length
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_issued |-> packet_address == '0 && packet_length == '0)
    else $error("packet fields set without a packet");

  // A zero-length packet after data moves to the zero-length wait state
  a_zlp_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_issued && !start_accepted && packet_length == '0
      |-> tx_state == TXS_BUSY_ZLP)
    else $error("zero-length packet outside zero-length phase");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(packet_address)
      && $stable(tx_state))
    else $error("result beat changed while stalled");

endmodule

bind bulk_transfer_packet_segmenter bts_checker u_bts_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .packet_issued  (packet_issued),
  .packet_address (packet_address),
  .packet_length  (packet_length),
  .start_accepted (start_accepted),
  .tx_state       (tx_state)
);
